// ===== hw/rtl/pms_pkg.sv =====
// Package for the plotter motion supervisor: codes and channel word types.
package pms_pkg;

   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_HOME        = 3'd1,
      OP_MOVE        = 3'd2,
      OP_ABORT       = 3'd3,
      OP_FAULT_RESET = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      MODE_INIT   = 3'd0,
      MODE_IDLE   = 3'd1,
      MODE_HOMING = 3'd2,
      MODE_MOVING = 3'd3,
      MODE_FAULT  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CAUSE_NONE         = 3'd0,
      CAUSE_INIT_FAILED  = 3'd1,
      CAUSE_HOMING_LIMIT = 3'd2,
      CAUSE_MOVE_LIMIT   = 3'd3,
      CAUSE_INVALID      = 3'd4,
      CAUSE_TIMEOUT      = 3'd5
   } cause_type;

   // bit positions in the limit and mask vectors
   localparam int unsigned LIM_LEFT   = 0;
   localparam int unsigned LIM_RIGHT  = 1;
   localparam int unsigned LIM_BOTTOM = 2;
   localparam int unsigned LIM_TOP    = 3;
   localparam int unsigned LIM_COUNT  = 4;

   typedef struct packed {
      logic [2:0]         operation;
      logic               limit_left;
      logic               limit_right;
      logic               limit_bottom;
      logic               limit_top;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
      logic               homing_done;
      logic               motion_done;
      logic               motion_invalid;
      logic               motion_timeout;
      logic               init_ok;
   } req_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       start_homing;
      logic       start_move;
      logic       stop_motors;
      logic       abort_motion;
      logic       move_rejected;
      logic [2:0] fault_cause;
   } rsp_type;

endpackage

// ===== hw/rtl/pms_req_if.sv =====
// Request channel: valid/ready handshake carrying one command word.
interface pms_req_if;
   import pms_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pms_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one status word.
interface pms_rsp_if;
   import pms_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/plotter_motion_supervisor_core.sv =====
// Plotter motion supervisor: mode state machine with limit masking.
// A word passes the input register, then decision logic into the response
// register. Throughput: one word per cycle unless the response stalls; the
// mode and mask registers update as a word leaves the input register, so
// the next word sees them at once.
// Reset: synchronous, active high; mode returns to initializing, masks clear,
// both pipeline registers empty.
module plotter_motion_supervisor_core (
   input logic       clock,
   input logic       reset,
   pms_req_if.sink   req_chan,
   pms_rsp_if.source rsp_chan
);
   import pms_pkg::*;

   logic                 in_valid_ff;
   req_type              in_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   mode_type             mode_ff;
   logic [LIM_COUNT-1:0] mask_ff;

   mode_type             mode_in;
   logic [LIM_COUNT-1:0] mask_in;
   rsp_type              rsp_in;

   logic                 load;
   logic                 take;
   logic [LIM_COUNT-1:0] lim;
   logic                 tx_neg, tx_pos, ty_neg, ty_pos;
   logic                 reject;
   logic                 home_hit;
   logic                 move_hit;
   logic                 known_mode;

   assign load = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || load;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   assign lim[LIM_LEFT]   = in_ff.limit_left;
   assign lim[LIM_RIGHT]  = in_ff.limit_right;
   assign lim[LIM_BOTTOM] = in_ff.limit_bottom;
   assign lim[LIM_TOP]    = in_ff.limit_top;

   assign tx_neg = in_ff.target_x[15];
   assign tx_pos = !in_ff.target_x[15] && (|in_ff.target_x);
   assign ty_neg = in_ff.target_y[15];
   assign ty_pos = !in_ff.target_y[15] && (|in_ff.target_y);

   assign reject = (lim[LIM_LEFT] && tx_neg) || (lim[LIM_RIGHT] && tx_pos) ||
                   (lim[LIM_BOTTOM] && ty_neg) || (lim[LIM_TOP] && ty_pos);

   // a pressed switch stays masked only if it was masked before
   assign home_hit = (lim[LIM_RIGHT] && !mask_ff[LIM_RIGHT]) ||
                     (lim[LIM_TOP] && !mask_ff[LIM_TOP]);
   assign move_hit = |(lim & ~mask_ff);

   assign known_mode = mode_ff inside {MODE_INIT, MODE_IDLE, MODE_HOMING, MODE_MOVING};

   // next state and masks
   always_comb begin
      mode_in = mode_ff;
      mask_in = mask_ff;
      case (in_ff.operation)
         OP_TICK: begin
            case (mode_ff)
               MODE_INIT: begin
                  if (in_ff.init_ok) begin
                     mask_in = lim;
                     mode_in = MODE_HOMING;
                  end else begin
                     mode_in = MODE_FAULT;
                  end
               end
               MODE_IDLE: begin
               end
               MODE_HOMING: begin
                  mask_in[LIM_RIGHT] = mask_ff[LIM_RIGHT] & lim[LIM_RIGHT];
                  mask_in[LIM_TOP]   = mask_ff[LIM_TOP] & lim[LIM_TOP];
                  if (home_hit) begin
                     mode_in = MODE_FAULT;
                  end else if (in_ff.homing_done) begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_MOVING: begin
                  mask_in = mask_ff & lim;
                  if (move_hit || in_ff.motion_invalid) begin
                     mode_in = MODE_FAULT;
                  end else if (in_ff.motion_done) begin
                     mode_in = MODE_IDLE;
                  end else if (in_ff.motion_timeout) begin
                     mode_in = MODE_FAULT;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_HOME: begin
            if (mode_ff == MODE_IDLE) begin
               mask_in = lim;
               mode_in = MODE_HOMING;
            end
         end
         OP_MOVE: begin
            if (mode_ff == MODE_IDLE && !reject) begin
               mask_in = lim;
               mode_in = MODE_MOVING;
            end
         end
         OP_ABORT: begin
            mode_in = MODE_IDLE;
         end
         OP_FAULT_RESET: begin
            if (!known_mode) begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   // response word
   always_comb begin
      rsp_in               = '0;
      rsp_in.mode          = mode_in;
      rsp_in.fault_cause   = CAUSE_NONE;
      case (in_ff.operation)
         OP_TICK: begin
            case (mode_ff)
               MODE_INIT: begin
                  if (!in_ff.init_ok) begin
                     rsp_in.fault_cause = CAUSE_INIT_FAILED;
                  end
               end
               MODE_IDLE: begin
               end
               MODE_HOMING: begin
                  if (home_hit) begin
                     rsp_in.stop_motors = 1'b1;
                     rsp_in.fault_cause = CAUSE_HOMING_LIMIT;
                  end
               end
               MODE_MOVING: begin
                  if (move_hit) begin
                     rsp_in.fault_cause = CAUSE_MOVE_LIMIT;
                  end else if (in_ff.motion_invalid) begin
                     rsp_in.fault_cause = CAUSE_INVALID;
                  end else if (!in_ff.motion_done && in_ff.motion_timeout) begin
                     rsp_in.fault_cause = CAUSE_TIMEOUT;
                  end
               end
               default: begin
                  rsp_in.stop_motors = 1'b1;
               end
            endcase
         end
         OP_HOME: begin
            rsp_in.start_homing = (mode_ff == MODE_IDLE);
         end
         OP_MOVE: begin
            rsp_in.start_move    = (mode_ff == MODE_IDLE) && !reject;
            rsp_in.move_rejected = (mode_ff == MODE_IDLE) && reject;
         end
         OP_ABORT: begin
            rsp_in.abort_motion = 1'b1;
         end
         default: begin
         end
      endcase
      if (mode_ff == MODE_MOVING && mode_in != MODE_MOVING) begin
         rsp_in.abort_motion = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_INIT;
         mask_ff      <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            mask_ff      <= mask_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_chan.data;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   a_mode_tracks_rsp: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_ff.mode == mode_ff))
      else $error("mode register differs from last response word");

   a_cause_in_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fault_cause != CAUSE_NONE) |-> (rsp_ff.mode == MODE_FAULT))
      else $error("fault cause given outside fault mode");

   a_start_move_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.start_move) |-> (rsp_ff.mode == MODE_MOVING && !rsp_ff.move_rejected))
      else $error("start_move without entering moving");

endmodule
